// ----- hw/rtl/md5_single_block_digest_macros.svh -----
// assertion macros shared by the md5 digest rtl
`ifndef MD5_SINGLE_BLOCK_DIGEST_MACROS_SVH
`define MD5_SINGLE_BLOCK_DIGEST_MACROS_SVH

// same-cycle implication, masked while reset is held
`define MD5_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is held
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/md5_pkg.sv -----
// types, constants and helper functions for the md5 digest block
package md5_pkg;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] word;
    } t_word_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_result;

    localparam logic [3:0] LAST_WORD_INDEX = 4'd15;
    localparam logic [5:0] LAST_ROUND      = 6'd63;
    localparam logic [1:0] LAST_DIGEST     = 2'd3;

    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotation amounts, indexed by {group, round[1:0]}
    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] round_f(
        input logic [1:0]  grp,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        logic [31:0] f;
        unique case (grp)
            GRP_F:   f = ((c ^ d) & b) ^ d;
            GRP_G:   f = ((b ^ c) & d) ^ c;
            GRP_H:   f = b ^ c ^ d;
            GRP_I:   f = (~d | b) ^ c;
            default: f = '0;
        endcase
        return f;
    endfunction

    // message word schedule
    function automatic logic [3:0] msg_sel(input logic [5:0] rnd);
        logic [7:0] prod;
        unique case (rnd[5:4])
            GRP_F:   prod = {2'b00, rnd};
            GRP_G:   prod = {2'b00, rnd} * 8'd5 + 8'd1;
            GRP_H:   prod = {2'b00, rnd} * 8'd3 + 8'd5;
            GRP_I:   prod = {2'b00, rnd} * 8'd7;
            default: prod = '0;
        endcase
        return prod[3:0];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
        return (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

endpackage

// ----- hw/rtl/md5_fifo.sv -----
// small register queue with show-ahead head
`include "md5_single_block_digest_macros.svh"

module md5_fifo #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `MD5_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "queue count beyond depth")
    `MD5_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

// ----- hw/rtl/md5_front.sv -----
// front end: takes word beats and tags each with its place in the block
module md5_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [31:0]         i_message_word,
    output logic                o_full,
    output md5_pkg::t_word_beat o_beat,
    output logic                o_beat_push,
    input  logic                i_queue_full
);

    logic [3:0] r_word_cnt, n_word_cnt;
    logic       accept;

    assign o_full      = i_queue_full;
    assign accept      = i_push && !i_queue_full;
    assign o_beat_push = accept;
    assign o_beat      = '{index: r_word_cnt, word: i_message_word};

    // wraps from fifteen back to zero: the next beat opens a fresh block
    assign n_word_cnt = accept ? r_word_cnt + 1'b1 : r_word_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_cnt <= '0;
        end else begin
            r_word_cnt <= n_word_cnt;
        end
    end

endmodule

// ----- hw/rtl/md5_back.sv -----
// back end: block buffer, one-round-per-cycle compression engine, digest emit
`include "md5_single_block_digest_macros.svh"

module md5_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  md5_pkg::t_word_beat i_beat,
    input  logic                i_beat_avail,
    output logic                o_beat_pop,
    output md5_pkg::t_result    o_result,
    output logic                o_result_push,
    input  logic                i_result_full
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [31:0] r_buf [16];
    logic [1:0]  r_state, n_state;
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_emit_idx, n_emit_idx;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [31:0] r_km;
    logic [5:0]  km_round;
    logic [1:0]  grp;
    logic [31:0] f_val, t_sum, t_rot;
    logic [31:0] sel_reg;
    logic        load_last;

    assign o_beat_pop    = (r_state == ST_LOAD) && i_beat_avail;
    assign load_last     = o_beat_pop && (i_beat.index == md5_pkg::LAST_WORD_INDEX);
    assign o_result_push = (r_state == ST_EMIT) && !i_result_full;

    // one round
    assign grp   = r_round[5:4];
    assign f_val = md5_pkg::round_f(grp, r_b, r_c, r_d);
    assign t_sum = r_a + f_val + r_km;
    assign t_rot = md5_pkg::rotl(t_sum, md5_pkg::ROT_AMT[{grp, r_round[1:0]}]);

    // constant plus message word for the round after this one
    assign km_round = (r_state == ST_LOAD) ? '0 : r_round + 1'b1;

    always_comb begin
        unique case (r_emit_idx)
            2'd0:    sel_reg = r_a;
            2'd1:    sel_reg = r_b;
            2'd2:    sel_reg = r_c;
            2'd3:    sel_reg = r_d;
            default: sel_reg = r_a;
        endcase
    end

    assign o_result = '{
        digest_word: sel_reg + md5_pkg::MD5_IV[r_emit_idx],
        word_index:  r_emit_idx,
        last_word:   (r_emit_idx == md5_pkg::LAST_DIGEST)
    };

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_emit_idx = r_emit_idx;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_d        = r_d;
        unique case (r_state)
            ST_LOAD: begin
                if (load_last) begin
                    n_state = ST_ROUND;
                    n_round = '0;
                    n_a     = md5_pkg::MD5_IV[0];
                    n_b     = md5_pkg::MD5_IV[1];
                    n_c     = md5_pkg::MD5_IV[2];
                    n_d     = md5_pkg::MD5_IV[3];
                end
            end
            ST_ROUND: begin
                n_a     = r_d;
                n_b     = t_rot + r_b;
                n_c     = r_b;
                n_d     = r_c;
                n_round = r_round + 1'b1;
                if (r_round == md5_pkg::LAST_ROUND) begin
                    n_state    = ST_EMIT;
                    n_emit_idx = '0;
                end
            end
            ST_EMIT: begin
                if (o_result_push) begin
                    n_emit_idx = r_emit_idx + 1'b1;
                    if (r_emit_idx == md5_pkg::LAST_DIGEST) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_round    <= '0;
            r_emit_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_emit_idx <= n_emit_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
    end

    // word zero is always in place before the last word of a block arrives
    always_ff @(posedge i_clk) begin
        if (o_beat_pop) begin
            r_buf[i_beat.index] <= i_beat.word;
        end
        r_km <= md5_pkg::SINE_K[km_round] + r_buf[md5_pkg::msg_sel(km_round)];
    end

    `MD5_ASSERT_NEXT(a_round_to_emit, i_clk, i_rst_n, r_state == ST_ROUND && r_round == md5_pkg::LAST_ROUND, r_state == ST_EMIT, "rounds did not hand over to emit")
    `MD5_ASSERT_IMPLY(a_pop_in_load, i_clk, i_rst_n, o_beat_pop, r_state == ST_LOAD, "word taken outside load")
    `MD5_ASSERT_NEXT(a_last_to_load, i_clk, i_rst_n, o_result_push && o_result.last_word, r_state == ST_LOAD, "emit did not return to load")

endmodule

// ----- hw/rtl/md5_single_block_digest.sv -----
// top level of the md5 single-block digest
//
// takes one 64-byte block as sixteen 32-bit little-endian word beats on the
// push/full side and returns four digest word beats (a, b, c, d, the last
// flagged) on the empty/pop side, each the final working register plus the
// standard initial vector; every block starts from that vector, so there is
// no chaining, padding or length handling here. a front end counts the beats
// and tags each with its place in the block; a word queue of
// WORD_QUEUE_DEPTH entries parts it from the back end, which fills a
// sixteen-word block buffer, runs the 64 rounds one per cycle on a single
// round unit and writes the digest into a result queue of
// RESULT_QUEUE_DEPTH entries. a block passes through sixteen buffer loads,
// the 64 rounds and four digest beats, and the back end takes no word of
// the next block until its digest is out. while the rounds run, the
// front end keeps taking words of the next block until the word queue
// fills, and full rises only then. the back end holds in emit while the
// result queue is full, so a slow consumer only stalls, nothing is dropped
module md5_single_block_digest #(
    parameter int WORD_QUEUE_DEPTH   = 4,
    parameter int RESULT_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // word side
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_message_word,
    // digest side
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    localparam int BEAT_W   = $bits(md5_pkg::t_word_beat);
    localparam int RESULT_W = $bits(md5_pkg::t_result);

    md5_pkg::t_word_beat front_beat;
    md5_pkg::t_word_beat back_beat;
    md5_pkg::t_result    back_result;
    md5_pkg::t_result    head_result;
    logic                front_push;
    logic                word_q_full;
    logic                word_q_empty;
    logic                back_pop;
    logic                result_push;
    logic                result_q_full;
    logic [BEAT_W-1:0]   word_q_head;
    logic [RESULT_W-1:0] result_q_head;

    // front end: beat counting and tagging
    md5_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_message_word (i_message_word),
        .o_full         (full),
        .o_beat         (front_beat),
        .o_beat_push    (front_push),
        .i_queue_full   (word_q_full)
    );

    // word queue between the two halves
    md5_fifo #(
        .WIDTH (BEAT_W),
        .DEPTH (WORD_QUEUE_DEPTH)
    ) u_word_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_beat),
        .o_full  (word_q_full),
        .i_pop   (back_pop),
        .o_data  (word_q_head),
        .o_empty (word_q_empty)
    );

    assign back_beat = md5_pkg::t_word_beat'(word_q_head);

    // back end: buffer, rounds and digest
    md5_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (back_beat),
        .i_beat_avail  (!word_q_empty),
        .o_beat_pop    (back_pop),
        .o_result      (back_result),
        .o_result_push (result_push),
        .i_result_full (result_q_full)
    );

    // result queue, its head drives the digest ports
    md5_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_push),
        .i_data  (back_result),
        .o_full  (result_q_full),
        .i_pop   (pop),
        .o_data  (result_q_head),
        .o_empty (empty)
    );

    assign head_result   = md5_pkg::t_result'(result_q_head);
    assign o_digest_word = head_result.digest_word;
    assign o_word_index  = head_result.word_index;
    assign o_last_word   = head_result.last_word;

endmodule
